>>> hw/rtl/dpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Register codes, fixed field widths, reset values and saturation helpers
// shared by the back-projection pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Fixed widths of the configuration registers and fields.
  localparam int WH_W    = 13;  // image width and height
  localparam int GAIN_W  = 24;  // depth gain and depth offset
  localparam int OPT_W   = 16;  // focal length and sensor width
  localparam int CODE_W  = 8;   // raw depth code
  localparam int OUT_W   = 32;  // Q16.16 point coordinates
  localparam int CFG_W   = 24;  // widest register
  localparam int IDX_W   = 3;   // register index

  // Scaled depth: unsigned code times gain, minus a signed offset.
  localparam int PROD_W  = GAIN_W + CODE_W;
  localparam int D_W     = PROD_W + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_DEPTH_GAIN     = 3'd2,
    REG_DEPTH_OFFSET   = 3'd3,
    REG_FOCAL_LENGTH   = 3'd4,
    REG_SENSOR_WIDTH   = 3'd5,
    REG_DOUBLED_COORDS = 3'd6
  } cfg_reg_t;

  localparam logic [WH_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [WH_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [GAIN_W-1:0] RST_DEPTH_GAIN   = 24'd257;
  localparam logic [GAIN_W-1:0] RST_DEPTH_OFFSET = 24'd0;
  localparam logic [OPT_W-1:0]  RST_FOCAL_LENGTH = 16'd8960;
  localparam logic [OPT_W-1:0]  RST_SENSOR_WIDTH = 16'd9216;

  localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

  // Applies the sign to a rounded quotient magnitude and clamps it to the
  // signed 32-bit range. The overflow flag marks a quotient of 2^32 or more.
  function automatic logic [OUT_W-1:0] sat_quot(input logic [OUT_W-1:0] q,
                                                input logic ovf,
                                                input logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      if (ovf || (q > SAT_MIN)) r = SAT_MIN;
      else r = ~q + 32'd1;
    end else begin
      if (ovf || q[OUT_W-1]) r = SAT_MAX;
      else r = q;
    end
    return r;
  endfunction

  // Clamps the signed scaled depth to the signed 32-bit range.
  function automatic logic [OUT_W-1:0] sat_depth(input logic [D_W-1:0] d);
    logic [D_W-OUT_W:0] top;
    logic [OUT_W-1:0]   r;
    top = d[D_W-1 -: (D_W-OUT_W+1)];
    if ((&top) || !(|top)) r = d[OUT_W-1:0];
    else if (d[D_W-1]) r = SAT_MIN;
    else r = SAT_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dpb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth pixel back-projection channel interfaces
// Valid/ready channels for incoming depth pixels and outgoing points.
// ----------------------------------------------------------------------------
interface dpb_pixel_if #(
  parameter int COORD_BITS = 12
);
  logic                             valid;
  logic                             ready;
  logic [COORD_BITS-1:0]            pixel_x;
  logic [COORD_BITS-1:0]            pixel_y;
  logic [dpb_pkg::CODE_W-1:0]       depth_code;

  modport source (output valid, output pixel_x, output pixel_y, output depth_code,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input depth_code,
                  output ready);
endinterface

interface dpb_point_if;
  logic                             valid;
  logic                             ready;
  logic signed [dpb_pkg::OUT_W-1:0] point_x;
  logic signed [dpb_pkg::OUT_W-1:0] point_y;
  logic signed [dpb_pkg::OUT_W-1:0] point_z;
  logic                             in_range;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output in_range, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input in_range, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/depth_pixel_backprojection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Turns one depth pixel into a Q16.16 camera-space point through a pinhole
// camera model, with bounds check, fallback point and output saturation.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one point word per
// pixel, in order, through the front stages of coordinate, depth and product
// arithmetic, the restoring divider that forms the rounded x and y quotients
// one bit per stage, and the output register. The divider is fully pipelined,
// so the sustained rate is one pixel per clock for as long as the point side
// keeps taking words. When the point side stalls, the whole pipeline holds,
// and one more pixel is caught in a skid register so that the pixel side
// ready is a plain register output. The user must write configuration
// registers through the cfg port only while no pixel is in flight; the block
// does not enforce this. Register indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dpb_pixel_if.sink                            in_pixel,
  dpb_point_if.source                          out_point,
  input  wire logic                            cfg_we,
  input  wire logic [dpb_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [dpb_pkg::CFG_W-1:0]       cfg_wdata
);

  // Working widths. The compare width covers both doubled coordinates and
  // image sizes; ray offsets need one more bit for the sign.
  localparam int CMPW  = (COORD_BITS + 1 > dpb_pkg::WH_W) ? COORD_BITS + 1
                                                           : dpb_pkg::WH_W;
  localparam int DXW   = CMPW + 1;
  localparam int DW    = dpb_pkg::D_W;
  localparam int DMW   = DW - 1;
  localparam int M1W   = DMW + dpb_pkg::OPT_W;
  localparam int MAGW  = M1W + CMPW;
  localparam int NW    = MAGW + 1;
  localparam int DENW  = dpb_pkg::OPT_W + dpb_pkg::WH_W;
  localparam int QW    = dpb_pkg::OUT_W;
  localparam int FRONT = 7;
  localparam int NST   = FRONT + QW + 1;
  localparam logic [QW-1:0] FALLBACK_Z = QW'(64'd10 << FRAC_BITS);

  typedef struct packed {
    logic          oor;
    logic          sx;
    logic          sy;
    logic          ovfx;
    logic          ovfy;
    logic [QW-1:0] z;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dpb_pkg::WH_W-1:0]   image_width_r;
  logic [dpb_pkg::WH_W-1:0]   image_height_r;
  logic [dpb_pkg::GAIN_W-1:0] depth_gain_r;
  logic [dpb_pkg::GAIN_W-1:0] depth_offset_r;
  logic [dpb_pkg::OPT_W-1:0]  focal_length_r;
  logic [dpb_pkg::OPT_W-1:0]  sensor_width_r;
  logic                       doubled_coords_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= dpb_pkg::RST_IMAGE_WIDTH;
      image_height_r   <= dpb_pkg::RST_IMAGE_HEIGHT;
      depth_gain_r     <= dpb_pkg::RST_DEPTH_GAIN;
      depth_offset_r   <= dpb_pkg::RST_DEPTH_OFFSET;
      focal_length_r   <= dpb_pkg::RST_FOCAL_LENGTH;
      sensor_width_r   <= dpb_pkg::RST_SENSOR_WIDTH;
      doubled_coords_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (dpb_pkg::cfg_reg_t'(cfg_index))
        dpb_pkg::REG_IMAGE_WIDTH:    image_width_r    <= cfg_wdata[dpb_pkg::WH_W-1:0];
        dpb_pkg::REG_IMAGE_HEIGHT:   image_height_r   <= cfg_wdata[dpb_pkg::WH_W-1:0];
        dpb_pkg::REG_DEPTH_GAIN:     depth_gain_r     <= cfg_wdata[dpb_pkg::GAIN_W-1:0];
        dpb_pkg::REG_DEPTH_OFFSET:   depth_offset_r   <= cfg_wdata[dpb_pkg::GAIN_W-1:0];
        dpb_pkg::REG_FOCAL_LENGTH:   focal_length_r   <= cfg_wdata[dpb_pkg::OPT_W-1:0];
        dpb_pkg::REG_SENSOR_WIDTH:   sensor_width_r   <= cfg_wdata[dpb_pkg::OPT_W-1:0];
        dpb_pkg::REG_DOUBLED_COORDS: doubled_coords_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The divisor focal * width depends on configuration only, so it is formed
  // once per cycle here. It settles long before any pixel reaches the divider.
  logic [DENW-1:0] den_r;
  logic [DENW-1:0] half_den;

  always_ff @(posedge clk) begin
    den_r <= DENW'(focal_length_r) * DENW'(image_width_r);
  end

  assign half_den = den_r >> 1;

  // --------------------------------------------------------------------------
  // Handshake: global pipeline enable and input skid register
  // --------------------------------------------------------------------------
  logic [NST-1:0]             vld_r;
  logic                       en;
  logic                       take_in;
  logic                       skid_full_r;
  logic [COORD_BITS-1:0]      skid_x_r;
  logic [COORD_BITS-1:0]      skid_y_r;
  logic [dpb_pkg::CODE_W-1:0] skid_code_r;
  logic                       s1_vld_nxt;

  assign en             = !vld_r[NST-1] || out_point.ready;
  assign in_pixel.ready = !skid_full_r;
  assign take_in        = in_pixel.valid && !skid_full_r;
  assign s1_vld_nxt     = skid_full_r || take_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (take_in) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && take_in) begin
      skid_x_r    <= in_pixel.pixel_x;
      skid_y_r    <= in_pixel.pixel_y;
      skid_code_r <= in_pixel.depth_code;
    end
  end

  // Valid bits march alongside the payload, one per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], s1_vld_nxt};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pixel register
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0]      x1_r;
  logic [COORD_BITS-1:0]      y1_r;
  logic [dpb_pkg::CODE_W-1:0] code1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= skid_full_r ? skid_x_r    : in_pixel.pixel_x;
      y1_r    <= skid_full_r ? skid_y_r    : in_pixel.pixel_y;
      code1_r <= skid_full_r ? skid_code_r : in_pixel.depth_code;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: optional doubling, bounds check, ray offsets, code * gain
  // --------------------------------------------------------------------------
  logic [CMPW-1:0]             xc;
  logic [CMPW-1:0]             yc;
  logic [CMPW-1:0]             wc;
  logic [CMPW-1:0]             hc;
  logic                        oor2_r;
  logic [DXW-1:0]              dx2_r;
  logic [DXW-1:0]              dy2_r;
  logic [dpb_pkg::PROD_W-1:0]  gprod2_r;

  assign xc = doubled_coords_r ? CMPW'({x1_r, 1'b0}) : CMPW'(x1_r);
  assign yc = doubled_coords_r ? CMPW'({y1_r, 1'b0}) : CMPW'(y1_r);
  assign wc = CMPW'(image_width_r);
  assign hc = CMPW'(image_height_r);

  always_ff @(posedge clk) begin
    if (en) begin
      oor2_r   <= (xc >= wc) || (yc >= hc);
      // dx = x - floor(w/2); dy = (h - y) - floor(h/2), rows count upward.
      dx2_r    <= DXW'(xc) - DXW'(wc >> 1);
      dy2_r    <= DXW'(hc - (hc >> 1)) - DXW'(yc);
      gprod2_r <= dpb_pkg::PROD_W'(code1_r) * dpb_pkg::PROD_W'(depth_gain_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: depth minus offset, offset magnitudes and signs
  // --------------------------------------------------------------------------
  logic [DW-1:0]   d3_r;
  logic [DXW-1:0]  dx_neg;
  logic [DXW-1:0]  dy_neg;
  logic [CMPW-1:0] dxm3_r;
  logic [CMPW-1:0] dym3_r;
  logic            dxs3_r;
  logic            dys3_r;
  logic            oor3_r;

  assign dx_neg = ~dx2_r + DXW'(1);
  assign dy_neg = ~dy2_r + DXW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r   <= {2'b00, gprod2_r}
                - {{(DW-dpb_pkg::GAIN_W){depth_offset_r[dpb_pkg::GAIN_W-1]}},
                   depth_offset_r};
      dxs3_r <= dx2_r[DXW-1];
      dys3_r <= dy2_r[DXW-1];
      dxm3_r <= dx2_r[DXW-1] ? dx_neg[CMPW-1:0] : dx2_r[CMPW-1:0];
      dym3_r <= dy2_r[DXW-1] ? dy_neg[CMPW-1:0] : dy2_r[CMPW-1:0];
      oor3_r <= oor2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: depth magnitude and saturated depth output
  // --------------------------------------------------------------------------
  logic [DW-1:0]   d_neg;
  logic [DMW-1:0]  dm4_r;
  logic [QW-1:0]   z4_r;
  logic            sx4_r;
  logic            sy4_r;
  logic [CMPW-1:0] dxm4_r;
  logic [CMPW-1:0] dym4_r;
  logic            oor4_r;

  assign d_neg = ~d3_r + DW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      dm4_r  <= d3_r[DW-1] ? d_neg[DMW-1:0] : d3_r[DMW-1:0];
      z4_r   <= dpb_pkg::sat_depth(d3_r);
      // The sign of each quotient is the product of the two factor signs.
      sx4_r  <= d3_r[DW-1] ^ dxs3_r;
      sy4_r  <= d3_r[DW-1] ^ dys3_r;
      dxm4_r <= dxm3_r;
      dym4_r <= dym3_r;
      oor4_r <= oor3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: |d| * sensor_width
  // --------------------------------------------------------------------------
  logic [M1W-1:0]  m15_r;
  logic [QW-1:0]   z5_r;
  logic            sx5_r;
  logic            sy5_r;
  logic [CMPW-1:0] dxm5_r;
  logic [CMPW-1:0] dym5_r;
  logic            oor5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m15_r  <= M1W'(dm4_r) * M1W'(sensor_width_r);
      z5_r   <= z4_r;
      sx5_r  <= sx4_r;
      sy5_r  <= sy4_r;
      dxm5_r <= dxm4_r;
      dym5_r <= dym4_r;
      oor5_r <= oor4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: numerator magnitudes |dx| * |d| * sw and |dy| * |d| * sw
  // --------------------------------------------------------------------------
  logic [MAGW-1:0] magx6_r;
  logic [MAGW-1:0] magy6_r;
  logic [QW-1:0]   z6_r;
  logic            sx6_r;
  logic            sy6_r;
  logic            oor6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      magx6_r <= MAGW'(m15_r) * MAGW'(dxm5_r);
      magy6_r <= MAGW'(m15_r) * MAGW'(dym5_r);
      z6_r    <= z5_r;
      sx6_r   <= sx5_r;
      sy6_r   <= sy5_r;
      oor6_r  <= oor5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: add half the divisor for round-half-away, detect quotients of
  // 2^32 or more, and split the numerator into the divider's start remainder
  // (upper bits, below the divisor when there is no overflow) and the bits
  // still to be shifted in.
  // --------------------------------------------------------------------------
  logic [NW-1:0]   nx;
  logic [NW-1:0]   ny;
  logic [NW-1:0]   nx_hi;
  logic [NW-1:0]   ny_hi;
  logic [DENW-1:0] remx7_r;
  logic [DENW-1:0] remy7_r;
  logic [QW-1:0]   nqx7_r;
  logic [QW-1:0]   nqy7_r;
  side_t           side7_r;

  assign nx    = NW'(magx6_r) + NW'(half_den);
  assign ny    = NW'(magy6_r) + NW'(half_den);
  assign nx_hi = nx >> QW;
  assign ny_hi = ny >> QW;

  always_ff @(posedge clk) begin
    if (en) begin
      remx7_r      <= nx_hi[DENW-1:0];
      remy7_r      <= ny_hi[DENW-1:0];
      nqx7_r       <= nx[QW-1:0];
      nqy7_r       <= ny[QW-1:0];
      side7_r.oor  <= oor6_r;
      side7_r.sx   <= sx6_r;
      side7_r.sy   <= sy6_r;
      side7_r.ovfx <= (nx_hi >= NW'(den_r));
      side7_r.ovfy <= (ny_hi >= NW'(den_r));
      side7_r.z    <= z6_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: both quotients in parallel, side data kept in step
  // --------------------------------------------------------------------------
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  side_t         side_r [QW];

  dpb_div_pipe #(
    .DEN_W (DENW),
    .Q_W   (QW)
  ) u_div_x (
    .clk    (clk),
    .en     (en),
    .den    (den_r),
    .rem_in (remx7_r),
    .nq_in  (nqx7_r),
    .q      (qx)
  );

  dpb_div_pipe #(
    .DEN_W (DENW),
    .Q_W   (QW)
  ) u_div_y (
    .clk    (clk),
    .en     (en),
    .den    (den_r),
    .rem_in (remy7_r),
    .nq_in  (nqy7_r),
    .q      (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side7_r;
      for (int i = 1; i < QW; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: fallback point, sign and saturation
  // --------------------------------------------------------------------------
  side_t         side_out;
  logic          fallback;
  logic          ray_flat;
  logic [QW-1:0] point_x_nxt;
  logic [QW-1:0] point_y_nxt;
  logic [QW-1:0] point_z_nxt;
  logic [QW-1:0] point_x_r;
  logic [QW-1:0] point_y_r;
  logic [QW-1:0] point_z_r;
  logic          in_range_r;

  assign side_out = side_r[QW-1];
  // A pixel outside the image, or a zero focal length, gives the fixed point
  // straight ahead at depth ten. A zero sensor width keeps the depth but
  // collapses the ray onto the optical axis.
  assign fallback = side_out.oor || (focal_length_r == '0);
  assign ray_flat = (sensor_width_r == '0);

  always_comb begin
    if (fallback) begin
      point_x_nxt = '0;
      point_y_nxt = '0;
      point_z_nxt = FALLBACK_Z;
    end else begin
      point_x_nxt = ray_flat ? '0 : dpb_pkg::sat_quot(qx, side_out.ovfx, side_out.sx);
      point_y_nxt = ray_flat ? '0 : dpb_pkg::sat_quot(qy, side_out.ovfy, side_out.sy);
      point_z_nxt = side_out.z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_x_r  <= point_x_nxt;
      point_y_r  <= point_y_nxt;
      point_z_r  <= point_z_nxt;
      in_range_r <= !fallback;
    end
  end

  assign out_point.valid    = vld_r[NST-1];
  assign out_point.point_x  = point_x_r;
  assign out_point.point_y  = point_y_r;
  assign out_point.point_z  = point_z_r;
  assign out_point.in_range = in_range_r;

endmodule
`default_nettype wire

>>> hw/rtl/dpb_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage. The remainder enters already reduced below the
// divisor; the low numerator bits shift out as the quotient bits shift in.
// ----------------------------------------------------------------------------
module dpb_div_pipe #(
  parameter int DEN_W = 29,
  parameter int Q_W   = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [DEN_W-1:0] rem_in,
  input  wire logic [Q_W-1:0]   nq_in,
  output logic      [Q_W-1:0]   q
);

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   nq_r  [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W-1:0] rem_src;
    logic [Q_W-1:0]   nq_src;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_src = rem_in;
      assign nq_src  = nq_in;
    end else begin : g_next
      assign rem_src = rem_r[i-1];
      assign nq_src  = nq_r[i-1];
    end

    assign trial = {rem_src, nq_src[Q_W-1]};
    assign ge    = (trial >= {1'b0, den});
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[i]  <= {nq_src[Q_W-2:0], ge};
      end
    end
  end

  assign q = nq_r[Q_W-1];

endmodule
`default_nettype wire
